[src/assert_macros.svh]
// Assertion shorthands used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset has been released
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/nfde_pkg.sv]
`default_nettype none
package nfde_pkg;

  // Screen geometry and store size
  localparam int SCREEN_WIDTH  = 960;
  localparam int SCREEN_HEIGHT = 540;
  localparam int FRAME_BYTES   = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;
  localparam int AB            = $clog2(FRAME_BYTES);
  localparam int PB            = AB + 1;
  localparam int XB            = $clog2(SCREEN_WIDTH + 1);
  localparam int YB            = $clog2(SCREEN_HEIGHT + 1);

  // Internal coordinate width, room for offsets past the 12-bit fields
  localparam int CW = 16;
  typedef logic signed [CW-1:0] coord_t;

  // Stream widths
  localparam int IN_W  = 72;
  localparam int OUT_W = 40;

  // Hash constants
  localparam logic [31:0] HASH_OFFSET = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME  = 32'd16777619;

  // Opcodes
  localparam logic [2:0] OP_SET     = 3'd0;
  localparam logic [2:0] OP_GET     = 3'd1;
  localparam logic [2:0] OP_FILL    = 3'd2;
  localparam logic [2:0] OP_OUTLINE = 3'd3;
  localparam logic [2:0] OP_GLYPH   = 3'd4;
  localparam logic [2:0] OP_SUM     = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NEXT,
    ST_SETUP,
    ST_RD,
    ST_WR,
    ST_SUM,
    ST_SUMT,
    ST_DONE
  } state_t;

  // 3x5 glyph, rows top to bottom, each row MSB = left column; bit 14 is the top-left dot
  function automatic logic [14:0] glyph_bits(input logic [7:0] code);
    logic [7:0]  uc;
    logic [14:0] g;
    uc = code;
    if (code >= 8'h61 && code <= 8'h7a) uc = code - 8'd32;
    case (uc)
      8'h41: g = 15'b111_101_111_101_101;
      8'h42: g = 15'b110_101_110_101_110;
      8'h43: g = 15'b111_100_100_100_111;
      8'h44: g = 15'b110_101_101_101_110;
      8'h45: g = 15'b111_100_110_100_111;
      8'h46: g = 15'b111_100_110_100_100;
      8'h47: g = 15'b111_100_101_101_111;
      8'h48: g = 15'b101_101_111_101_101;
      8'h49: g = 15'b111_010_010_010_111;
      8'h4a: g = 15'b001_001_001_101_111;
      8'h4b: g = 15'b101_101_110_101_101;
      8'h4c: g = 15'b100_100_100_100_111;
      8'h4d: g = 15'b101_111_111_101_101;
      8'h4e: g = 15'b101_111_111_111_101;
      8'h4f: g = 15'b111_101_101_101_111;
      8'h50: g = 15'b111_101_111_100_100;
      8'h51: g = 15'b111_101_101_111_001;
      8'h52: g = 15'b111_101_111_110_101;
      8'h53: g = 15'b111_100_111_001_111;
      8'h54: g = 15'b111_010_010_010_010;
      8'h55: g = 15'b101_101_101_101_111;
      8'h56: g = 15'b101_101_101_101_010;
      8'h57: g = 15'b101_101_111_111_101;
      8'h58: g = 15'b101_101_010_101_101;
      8'h59: g = 15'b101_101_010_010_010;
      8'h5a: g = 15'b111_001_010_100_111;
      8'h30: g = 15'b111_101_101_101_111;
      8'h31: g = 15'b010_110_010_010_111;
      8'h32: g = 15'b111_001_111_100_111;
      8'h33: g = 15'b111_001_111_001_111;
      8'h34: g = 15'b101_101_111_001_001;
      8'h35: g = 15'b111_100_111_001_111;
      8'h36: g = 15'b111_100_111_101_111;
      8'h37: g = 15'b111_001_001_010_010;
      8'h38: g = 15'b111_101_111_101_111;
      8'h39: g = 15'b111_101_111_001_111;
      8'h2d: g = 15'b000_000_111_000_000;
      8'h3a: g = 15'b000_010_000_010_000;
      8'h2f: g = 15'b001_001_010_100_100;
      default: g = 15'b0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

[src/nibble_framebuffer_draw_engine.sv]
// Channel | Direction | Contents
// in_     | slave     | one command per transfer
// out_    | master    | one result per command
//
// Each covered pixel is a byte read, then a merged write-back on one port.
// Each rectangle adds a pick and a clip step, each command an accept, a last pick and a
// result step; an outline is four rectangles, a glyph fifteen dots, a clear dot a pick only.
// Checksum: one read per frame byte, then a tail step. After reset a 0xFF clearing pass
// over all 259200 bytes, one a cycle, holds in_tready low. A stalled result waits in the output
// register; the next command is taken and holds only if it ends before that result leaves.
`default_nettype none
module nibble_framebuffer_draw_engine (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // opcode[2:0], pos_x[14:3], pos_y[26:15], width_px[38:27], height_px[50:39],
  // shade[54:51], char_code[62:55], glyph_scale[66:63], zero pad
  input  wire logic [nfde_pkg::IN_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // pixel_value[3:0], checksum_value[35:4], zero pad
  output logic [nfde_pkg::OUT_W-1:0]      out_tdata
);

  localparam int CW = nfde_pkg::CW;
  localparam int XB = nfde_pkg::XB;
  localparam int YB = nfde_pkg::YB;
  localparam int PB = nfde_pkg::PB;
  localparam int AB = nfde_pkg::AB;

  nfde_pkg::state_t state_r, state_nxt;

  logic [2:0]           op_r, op_nxt;
  nfde_pkg::coord_t     px_r, px_nxt, py_r, py_nxt, pw_r, pw_nxt, ph_r, ph_nxt;
  logic [3:0]           shade_r, shade_nxt, scale_r, scale_nxt;
  logic [14:0]          glyph_r, glyph_nxt;
  logic [3:0]           part_r, part_nxt;
  logic [1:0]           gc_r, gc_nxt;
  logic [5:0]           gox_r, gox_nxt, goy_r, goy_nxt;
  nfde_pkg::coord_t     rx_r, rx_nxt, ry_r, ry_nxt, rw_r, rw_nxt, rh_r, rh_nxt;
  logic [XB-1:0]        cx_r, cx_nxt, cx0_r, cx0_nxt, cx1_r, cx1_nxt;
  logic [YB-1:0]        cy_r, cy_nxt, cy1_r, cy1_nxt;
  logic [PB-1:0]        rowbase_r, rowbase_nxt;
  logic [AB-1:0]        sc_r, sc_nxt;
  logic                 vld_r, vld_nxt;
  logic [31:0]          hash_r, hash_nxt;
  logic [3:0]           pix_r, pix_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [nfde_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  // Frame memory, single port
  logic [7:0]    mem [nfde_pkg::FRAME_BYTES];
  logic [7:0]    rd_r;
  logic [AB-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_r <= mem[mem_addr];
  end

  // Clip terms for the current rectangle
  nfde_pkg::coord_t xe_c, ye_c, x0_c, x1_c, y0_c, y1_c;
  logic             empty_c;
  logic [PB-1:0]    paddr_c;
  logic [3:0]       nib_c;
  logic [3:0]       nparts_c;
  logic             last_c;

  always_comb begin
    xe_c    = rx_r + rw_r;
    ye_c    = ry_r + rh_r;
    x0_c    = rx_r[CW-1] ? '0 : rx_r;
    y0_c    = ry_r[CW-1] ? '0 : ry_r;
    x1_c    = (xe_c > nfde_pkg::coord_t'(nfde_pkg::SCREEN_WIDTH))
              ? nfde_pkg::coord_t'(nfde_pkg::SCREEN_WIDTH) : xe_c;
    y1_c    = (ye_c > nfde_pkg::coord_t'(nfde_pkg::SCREEN_HEIGHT))
              ? nfde_pkg::coord_t'(nfde_pkg::SCREEN_HEIGHT) : ye_c;
    empty_c = !(x0_c < x1_c) || !(y0_c < y1_c);
    paddr_c = rowbase_r + PB'(cx_r);
    nib_c   = cx_r[0] ? rd_r[7:4] : rd_r[3:0];
    last_c  = (XB'(cx_r + 1'b1) == cx1_r) && (YB'(cy_r + 1'b1) == cy1_r);
    case (op_r)
      nfde_pkg::OP_OUTLINE: nparts_c = 4'd4;
      nfde_pkg::OP_GLYPH:   nparts_c = 4'd15;
      default:              nparts_c = 4'd1;
    endcase
  end

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pw_nxt        = pw_r;
    ph_nxt        = ph_r;
    shade_nxt     = shade_r;
    scale_nxt     = scale_r;
    glyph_nxt     = glyph_r;
    part_nxt      = part_r;
    gc_nxt        = gc_r;
    gox_nxt       = gox_r;
    goy_nxt       = goy_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rw_nxt        = rw_r;
    rh_nxt        = rh_r;
    cx_nxt        = cx_r;
    cx0_nxt       = cx0_r;
    cx1_nxt       = cx1_r;
    cy_nxt        = cy_r;
    cy1_nxt       = cy1_r;
    rowbase_nxt   = rowbase_r;
    sc_nxt        = sc_r;
    vld_nxt       = 1'b0;
    hash_nxt      = hash_r;
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_addr      = paddr_c[PB-1:1];
    mem_wd        = cx_r[0] ? {shade_r, rd_r[3:0]} : {rd_r[7:4], shade_r};
    in_tready     = 1'b0;

    // checksum data arrives in the cycle after each read
    if (vld_r) hash_nxt = 32'((hash_r ^ {24'b0, rd_r}) * nfde_pkg::HASH_PRIME);

    case (state_r)
      nfde_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sc_r;
        mem_wd   = 8'hFF;
        sc_nxt   = AB'(sc_r + 1'b1);
        if (sc_r == AB'(nfde_pkg::FRAME_BYTES - 1)) begin
          sc_nxt    = '0;
          state_nxt = nfde_pkg::ST_IDLE;
        end
      end
      nfde_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_tdata[2:0];
          px_nxt    = {{(CW-12){in_tdata[14]}}, in_tdata[14:3]};
          py_nxt    = {{(CW-12){in_tdata[26]}}, in_tdata[26:15]};
          pw_nxt    = {{(CW-12){in_tdata[38]}}, in_tdata[38:27]};
          ph_nxt    = {{(CW-12){in_tdata[50]}}, in_tdata[50:39]};
          shade_nxt = in_tdata[54:51];
          glyph_nxt = nfde_pkg::glyph_bits(in_tdata[62:55]);
          scale_nxt = in_tdata[66:63];
          part_nxt  = '0;
          gc_nxt    = '0;
          gox_nxt   = '0;
          goy_nxt   = '0;
          pix_nxt   = '0;
          hash_nxt  = '0;
          sc_nxt    = '0;
          case (in_tdata[2:0])
            nfde_pkg::OP_SUM: begin
              hash_nxt  = nfde_pkg::HASH_OFFSET;
              state_nxt = nfde_pkg::ST_SUM;
            end
            nfde_pkg::OP_SET, nfde_pkg::OP_GET, nfde_pkg::OP_FILL,
            nfde_pkg::OP_OUTLINE, nfde_pkg::OP_GLYPH:
              state_nxt = nfde_pkg::ST_NEXT;
            default: state_nxt = nfde_pkg::ST_DONE;
          endcase
        end
      end
      // pick the next rectangle of the command
      nfde_pkg::ST_NEXT: begin
        if (part_r < nparts_c) begin
          part_nxt  = part_r + 4'd1;
          state_nxt = nfde_pkg::ST_SETUP;
          rx_nxt    = px_r;
          ry_nxt    = py_r;
          rw_nxt    = nfde_pkg::coord_t'(1);
          rh_nxt    = nfde_pkg::coord_t'(1);
          case (op_r)
            nfde_pkg::OP_FILL: begin
              rw_nxt = pw_r;
              rh_nxt = ph_r;
            end
            nfde_pkg::OP_OUTLINE: begin
              case (part_r[1:0])
                2'd0: rw_nxt = pw_r;
                2'd1: begin
                  rw_nxt = pw_r;
                  ry_nxt = py_r + ph_r - nfde_pkg::coord_t'(1);
                end
                2'd2: rh_nxt = ph_r;
                default: begin
                  rh_nxt = ph_r;
                  rx_nxt = px_r + pw_r - nfde_pkg::coord_t'(1);
                end
              endcase
            end
            nfde_pkg::OP_GLYPH: begin
              rx_nxt    = px_r + nfde_pkg::coord_t'(gox_r);
              ry_nxt    = py_r + nfde_pkg::coord_t'(goy_r);
              rw_nxt    = nfde_pkg::coord_t'(scale_r);
              rh_nxt    = nfde_pkg::coord_t'(scale_r);
              glyph_nxt = {glyph_r[13:0], 1'b0};
              if (gc_r == 2'd2) begin
                gc_nxt  = '0;
                gox_nxt = '0;
                goy_nxt = goy_r + 6'(scale_r);
              end else begin
                gc_nxt  = gc_r + 2'd1;
                gox_nxt = gox_r + 6'(scale_r);
              end
              if (!glyph_r[14] || scale_r == 4'd0) state_nxt = nfde_pkg::ST_NEXT;
            end
            default: ;
          endcase
        end else begin
          state_nxt = nfde_pkg::ST_DONE;
        end
      end
      // clip to the screen and form the first row address; an empty clip skips the rectangle, or answers 15 for a get
      nfde_pkg::ST_SETUP: begin
        if (empty_c) begin
          if (op_r == nfde_pkg::OP_GET) begin
            pix_nxt   = 4'd15;
            state_nxt = nfde_pkg::ST_DONE;
          end else begin
            state_nxt = nfde_pkg::ST_NEXT;
          end
        end else begin
          cx_nxt      = x0_c[XB-1:0];
          cx0_nxt     = x0_c[XB-1:0];
          cx1_nxt     = x1_c[XB-1:0];
          cy_nxt      = y0_c[YB-1:0];
          cy1_nxt     = y1_c[YB-1:0];
          rowbase_nxt = PB'(PB'(y0_c[YB-1:0]) * PB'(nfde_pkg::SCREEN_WIDTH));
          state_nxt   = nfde_pkg::ST_RD;
        end
      end
      nfde_pkg::ST_RD: state_nxt = nfde_pkg::ST_WR;
      // merge the nibble and step across the rectangle, or return the nibble for a get
      nfde_pkg::ST_WR: begin
        if (op_r == nfde_pkg::OP_GET) begin
          pix_nxt   = nib_c;
          state_nxt = nfde_pkg::ST_DONE;
        end else begin
          mem_we = 1'b1;
          if (last_c) begin
            state_nxt = nfde_pkg::ST_NEXT;
          end else begin
            state_nxt = nfde_pkg::ST_RD;
            if (XB'(cx_r + 1'b1) == cx1_r) begin
              cx_nxt      = cx0_r;
              cy_nxt      = YB'(cy_r + 1'b1);
              rowbase_nxt = PB'(rowbase_r + PB'(nfde_pkg::SCREEN_WIDTH));
            end else begin
              cx_nxt = XB'(cx_r + 1'b1);
            end
          end
        end
      end
      nfde_pkg::ST_SUM: begin
        mem_addr = sc_r;
        vld_nxt  = 1'b1;
        sc_nxt   = AB'(sc_r + 1'b1);
        if (sc_r == AB'(nfde_pkg::FRAME_BYTES - 1)) begin
          sc_nxt    = '0;
          state_nxt = nfde_pkg::ST_SUMT;
        end
      end
      nfde_pkg::ST_SUMT: state_nxt = nfde_pkg::ST_DONE;
      nfde_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, hash_r, pix_r};
          state_nxt     = nfde_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nfde_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfde_pkg::ST_CLEAR;
      sc_r        <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pw_r       <= pw_nxt;
    ph_r       <= ph_nxt;
    shade_r    <= shade_nxt;
    scale_r    <= scale_nxt;
    glyph_r    <= glyph_nxt;
    part_r     <= part_nxt;
    gc_r       <= gc_nxt;
    gox_r      <= gox_nxt;
    goy_r      <= goy_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    rw_r       <= rw_nxt;
    rh_r       <= rh_nxt;
    cx_r       <= cx_nxt;
    cx0_r      <= cx0_nxt;
    cx1_r      <= cx1_nxt;
    cy_r       <= cy_nxt;
    cy1_r      <= cy1_nxt;
    rowbase_r  <= rowbase_nxt;
    hash_r     <= hash_nxt;
    pix_r      <= pix_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

[src/nfde_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module nfde_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic [nfde_pkg::IN_W-1:0]  in_tdata,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [nfde_pkg::OUT_W-1:0] out_tdata
);

  // A stalled result is held
  `ASSERT_CLKRST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")

  // A waiting command stays offered and unchanged
  `ASSERT_CLKRST(a_in_hold, clk, rst_n, in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata), "command changed")

  // One command at a time: no transfer in the cycle after one
  `ASSERT_CLKRST(a_one_cmd, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "back-to-back accept")

  // A pixel result never carries a checksum, and the pad stays zero
  `ASSERT_CLKRST(a_fields, clk, rst_n, out_tvalid |-> (out_tdata[3:0] == 4'd0 || out_tdata[35:4] == 32'd0) && out_tdata[39:36] == 4'd0, "bad result fields")

  // Leaving reset: clearing pass under way, nothing offered
  `ASSERT_CLK(a_reset, clk, $past(!rst_n) |-> !in_tready && !out_tvalid, "active after reset")

endmodule

bind nibble_framebuffer_draw_engine nfde_checker u_nfde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
